// File: rtl/core/spmf_pkg.sv
// Package for the strict-priority multi-level job FIFO.
// Holds field widths, level and action codes, and the result record type.
// No dependencies.
package spmf_pkg;

    localparam int JOB_W      = 8;
    localparam int LEVEL_W    = 2;
    localparam int OCC_W      = 7;
    localparam int NUM_LEVELS = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_HIGH    = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW     = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_INVALID = 2'd3;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    // Result record handed from the queue controller to the output stage.
    typedef struct packed {
        logic               accepted;
        logic               deq_hit;
        logic [LEVEL_W-1:0] level;
        logic [OCC_W-1:0]   occupancy;
        logic [OCC_W-1:0]   peak;
        logic               pending;
    } spmf_result_t;

endpackage

// File: rtl/core/strict_priority_multi_fifo_top.sv
// Strict-priority three-level job FIFO, top level.
// done rises in the cycle after a transfer is taken, together with the registered RAM read.
// Throughput: one item per clock while busy is low; a new item may start in the cycle a result shows.
// Reset: asynchronous, active low; clears pointers and counts; busy is high for
// the first cycle after reset release. Results cannot be stalled by the receiver.
// Depends on spmf_pkg, spmf_ctrl and spmf_ram.
module strict_priority_multi_fifo_top #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           action,
    input  logic [spmf_pkg::LEVEL_W-1:0]   level,
    input  logic [spmf_pkg::JOB_W-1:0]     job_in,
    output logic                           done,
    output logic                           accepted,
    output logic [spmf_pkg::JOB_W-1:0]     job_out,
    output logic [spmf_pkg::LEVEL_W-1:0]   served_level,
    output logic [spmf_pkg::OCC_W-1:0]     occupancy,
    output logic [spmf_pkg::OCC_W-1:0]     peak_occupancy,
    output logic                           pending
);

    localparam int AW = $clog2(3 * QUEUE_DEPTH);

    logic                          go;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          ram_en;
    logic                          ram_we;
    logic [AW-1:0]                 ram_addr;
    logic [spmf_pkg::JOB_W-1:0]    ram_wdata;
    logic [spmf_pkg::JOB_W-1:0]    ram_rdata;
    spmf_pkg::spmf_result_t        res;
    spmf_pkg::spmf_result_t        res_reg;

    // A transfer is taken when start meets a free block.
    assign go = start && !busy_reg;

    // Pointer and count bank; decides the RAM access for this transfer.
    spmf_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .action    (action),
        .level     (level),
        .job_in    (job_in),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .res       (res)
    );

    // Job store: each level owns a contiguous block of QUEUE_DEPTH entries.
    spmf_ram #(
        .WIDTH (spmf_pkg::JOB_W),
        .DEPTH (3 * QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Hold busy for one cycle out of reset, then stay ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            done_reg <= go;
        end
    end

    // Capture the result record; the dequeued job arrives from the RAM in the same cycle.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            res_reg <= res;
        end
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign accepted       = res_reg.accepted;
    assign job_out        = res_reg.deq_hit ? ram_rdata : '0;
    assign served_level   = res_reg.level;
    assign occupancy      = res_reg.occupancy;
    assign peak_occupancy = res_reg.peak;
    assign pending        = res_reg.pending;

endmodule

// File: rtl/core/spmf_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
module spmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 192
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/spmf_ctrl.sv
// Queue controller: head/tail pointers, fill and peak counts per level,
// priority pick on dequeue, and the RAM access for each transfer.
// Depends on spmf_pkg.
module spmf_ctrl #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   go,
    input  logic                                   action,
    input  logic [spmf_pkg::LEVEL_W-1:0]           level,
    input  logic [spmf_pkg::JOB_W-1:0]             job_in,
    output logic                                   ram_en,
    output logic                                   ram_we,
    output logic [$clog2(3*QUEUE_DEPTH)-1:0]       ram_addr,
    output logic [spmf_pkg::JOB_W-1:0]             ram_wdata,
    output spmf_pkg::spmf_result_t                 res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = $clog2(3 * QUEUE_DEPTH);
    localparam int NL    = spmf_pkg::NUM_LEVELS;

    logic [PTR_W-1:0] head_reg [NL];
    logic [PTR_W-1:0] head_next[NL];
    logic [PTR_W-1:0] tail_reg [NL];
    logic [PTR_W-1:0] tail_next[NL];
    logic [CNT_W-1:0] fill_reg [NL];
    logic [CNT_W-1:0] fill_next[NL];
    logic [CNT_W-1:0] peak_reg [NL];
    logic [CNT_W-1:0] peak_next[NL];

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [AW-1:0] base(input logic [spmf_pkg::LEVEL_W-1:0] l);
        logic [AW-1:0] b;
        case (l)
            spmf_pkg::LEVEL_HIGH:   b = '0;
            spmf_pkg::LEVEL_MEDIUM: b = AW'(QUEUE_DEPTH);
            spmf_pkg::LEVEL_LOW:    b = AW'(2 * QUEUE_DEPTH);
            default:                b = '0;
        endcase
        return b;
    endfunction

    // Mask a count to the 7-bit report width, zero-extending narrow counts.
    function automatic logic [spmf_pkg::OCC_W-1:0] to_occ(input logic [CNT_W-1:0] c);
        logic [CNT_W+spmf_pkg::OCC_W-1:0] w;
        w = {{spmf_pkg::OCC_W{1'b0}}, c};
        return w[spmf_pkg::OCC_W-1:0];
    endfunction

    always_comb
    begin
        logic [1:0] sel;
        logic       found;
        for (int k = 0; k < NL; k++)
        begin
            head_next[k] = head_reg[k];
            tail_next[k] = tail_reg[k];
            fill_next[k] = fill_reg[k];
            peak_next[k] = peak_reg[k];
        end
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = job_in;
        res       = '0;
        sel       = '0;
        found     = 1'b0;

        if (action == spmf_pkg::ACT_ENQUEUE)
        begin
            if (level != spmf_pkg::LEVEL_INVALID)
            begin
                sel       = level;
                res.level = level;
                if (fill_reg[sel] != CNT_W'(QUEUE_DEPTH))
                begin
                    ram_en       = go;
                    ram_we       = 1'b1;
                    ram_addr     = base(sel) + AW'(tail_reg[sel]);
                    tail_next[sel] = adv(tail_reg[sel]);
                    fill_next[sel] = fill_reg[sel] + CNT_W'(1);
                    if (fill_next[sel] > peak_reg[sel])
                    begin
                        peak_next[sel] = fill_next[sel];
                    end
                    res.accepted = 1'b1;
                end
                res.occupancy = to_occ(fill_next[sel]);
                res.peak      = to_occ(peak_next[sel]);
            end
        end
        else
        begin
            // Lowest-numbered non-empty level wins.
            for (int k = NL - 1; k >= 0; k--)
            begin
                if (fill_reg[k] != '0)
                begin
                    sel   = 2'(k);
                    found = 1'b1;
                end
            end
            if (found)
            begin
                ram_en         = go;
                ram_addr       = base(sel) + AW'(head_reg[sel]);
                head_next[sel] = adv(head_reg[sel]);
                fill_next[sel] = fill_reg[sel] - CNT_W'(1);
                res.accepted   = 1'b1;
                res.deq_hit    = 1'b1;
                res.level      = sel;
                res.occupancy  = to_occ(fill_next[sel]);
                res.peak       = to_occ(peak_reg[sel]);
            end
        end

        for (int k = 0; k < NL; k++)
        begin
            if (fill_next[k] != '0)
            begin
                res.pending = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NL; k++)
            begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
                fill_reg[k] <= '0;
                peak_reg[k] <= '0;
            end
        end
        else if (go)
        begin
            for (int k = 0; k < NL; k++)
            begin
                head_reg[k] <= head_next[k];
                tail_reg[k] <= tail_next[k];
                fill_reg[k] <= fill_next[k];
                peak_reg[k] <= peak_next[k];
            end
        end
    end

endmodule

// File: rtl/core/spmf_checker.sv
// Port-level checker for the strict-priority job FIFO, bound to the top level.
// Depends on spmf_pkg and strict_priority_multi_fifo_top.
module spmf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           action,
    input logic                           done,
    input logic                           accepted,
    input logic [spmf_pkg::JOB_W-1:0]     job_out,
    input logic [spmf_pkg::LEVEL_W-1:0]   served_level,
    input logic [spmf_pkg::OCC_W-1:0]     occupancy,
    input logic [spmf_pkg::OCC_W-1:0]     peak_occupancy,
    input logic                           pending
);

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("transfer produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without a transfer");

    a_refused_job_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accepted) |-> (job_out == '0))
        else $error("refused item returned a job");

    a_enq_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted && $past(action) == spmf_pkg::ACT_ENQUEUE) |->
            (pending && occupancy <= peak_occupancy && occupancy != '0))
        else $error("stored job not reflected in counts");

    a_level_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (served_level != spmf_pkg::LEVEL_INVALID))
        else $error("invalid level reported");

endmodule

bind strict_priority_multi_fifo_top spmf_checker u_spmf_checker (.*);
